// File: hw/rtl/central_gravity_orbit_step_macros.svh
// Assertion macros shared by the orbit step RTL
`ifndef CENTRAL_GRAVITY_ORBIT_STEP_MACROS_SVH
`define CENTRAL_GRAVITY_ORBIT_STEP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define CGOS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define CGOS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cgos_pkg.sv
// Types, constants and helpers for the central gravity orbit step block
`timescale 1ns / 1ps
package cgos_pkg;

  localparam int unsigned MAX_PREDICT = 64;
  localparam int unsigned CNT_W       = 7;
  localparam logic [14:0] STEP_FACTOR = 15'd19968;
  localparam logic [63:0] SIGN_BIT    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

  // Command codes
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_PREDICT = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WORLD_SCALE = 2'd0,
    CFG_GRAVITY     = 2'd1,
    CFG_MIN_DIST2   = 2'd2
  } cfg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DX,
    ST_SQ,
    ST_ROOT,
    ST_INV,
    ST_ACC,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_PV,
    ST_PW,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic is_signed;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } unit_stat_t;

  // Two's complement magnitude (most negative maps to itself)
  function automatic logic [63:0] magnitude(input logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

endpackage

// File: hw/rtl/cgos_mul.sv
// Shared multiplier: 64x64 product from four 32x32 partial products, with saturation
`timescale 1ns / 1ps
`include "central_gravity_orbit_step_macros.svh"
module cgos_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cgos_pkg::mul_req_t    req_i,
  input  logic [63:0]           a_i,
  input  logic [63:0]           b_i,
  output cgos_pkg::unit_stat_t  stat_o,
  output logic [63:0]           res_o
);
  import cgos_pkg::*;

  logic [63:0]  a_q, b_q;
  logic         neg_q, sgn_q;
  logic [1:0]   cnt_q;
  logic         busy_q, done_q;
  logic [127:0] acc_q;

  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic         usat, psat;
  logic [63:0]  um;

  // Partial product for this cycle
  always_comb begin
    a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    pp     = 64'(a_part) * 64'(b_part);
    unique case (cnt_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and accumulator
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.is_signed ? magnitude(a_i) : a_i;
      b_q   <= b_i;
      neg_q <= req_i.is_signed & a_i[63];
      sgn_q <= req_i.is_signed;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  // Q32.32 truncation, unsigned saturation and signed packing
  always_comb begin
    usat = |acc_q[127:96];
    um   = usat ? '1 : acc_q[95:32];
    psat = 1'b0;
    if (!sgn_q) begin
      res_o = um;
    end else if (neg_q) begin
      if (um > SIGN_BIT) begin
        psat  = 1'b1;
        res_o = SIGN_BIT;
      end else begin
        res_o = ~um + 64'd1;
      end
    end else if (um[63]) begin
      psat  = 1'b1;
      res_o = POS_MAX;
    end else begin
      res_o = um;
    end
    stat_o.done = done_q;
    stat_o.sat  = usat | psat;
  end

  `CGOS_ASSERT_NOW(a_mul_no_restart, clk_i, rst_ni, req_i.start, !busy_q, "mul restarted while busy")
  `CGOS_ASSERT_NEXT(a_mul_start_busy, clk_i, rst_ni, req_i.start, busy_q && !done_q, "mul did not start")

endmodule

// File: hw/rtl/cgos_divsqrt.sv
// Shared shift-subtract unit: restoring division (one bit a cycle) and floor square root
`timescale 1ns / 1ps
`include "central_gravity_orbit_step_macros.svh"
module cgos_divsqrt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cgos_pkg::div_req_t    req_i,
  input  logic [63:0]           hi_i,
  input  logic [63:0]           lo_i,
  input  logic [63:0]           den_i,
  output cgos_pkg::unit_stat_t  stat_o,
  output logic [63:0]           res_o
);
  import cgos_pkg::*;

  logic [63:0] rem_q, q_q, d_q;
  logic [95:0] w_q;
  logic [5:0]  cnt_q;
  logic        sqrt_q, busy_q, done_q, sat_q;

  logic [65:0] sh, op, diff;
  logic        ge, bad_div;

  // One recurrence step, shared by both modes
  always_comb begin
    if (sqrt_q) begin
      sh = {rem_q, w_q[95:94]};
      op = {q_q, 2'b01};
    end else begin
      sh = {1'b0, rem_q, w_q[95]};
      op = {2'b00, d_q};
    end
    diff    = sh - op;
    ge      = !diff[65];
    bad_div = (den_i == 64'd0) || (hi_i >= den_i);
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (!req_i.sqrt_mode && bad_div) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= req_i.sqrt_mode ? 6'd47 : 6'd63;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqrt_q <= req_i.sqrt_mode;
      w_q    <= {lo_i, 32'd0};
      d_q    <= den_i;
      rem_q  <= req_i.sqrt_mode ? 64'd0 : hi_i;
      // quotient overflow or zero divisor saturates at once
      q_q    <= (!req_i.sqrt_mode && bad_div) ? '1 : 64'd0;
      sat_q  <= !req_i.sqrt_mode && bad_div;
    end else if (busy_q) begin
      rem_q <= ge ? diff[63:0] : sh[63:0];
      q_q   <= {q_q[62:0], ge};
      w_q   <= sqrt_q ? {w_q[93:0], 2'b00} : {w_q[94:0], 1'b0};
    end
  end

  assign res_o       = q_q;
  assign stat_o.done = done_q;
  assign stat_o.sat  = sat_q;

  `CGOS_ASSERT_NOW(a_div_no_restart, clk_i, rst_ni, req_i.start, !busy_q, "divsqrt restarted while busy")
  `CGOS_ASSERT_NOW(a_div_done_idle, clk_i, rst_ni, done_q, !busy_q, "divsqrt done while busy")

endmodule

// File: hw/rtl/central_gravity_orbit_step.sv
// Top level: command sequencer, body state and result register of the orbit step block
//
// Moves one body toward the origin by semi-implicit Euler steps in signed Q32.32.
// Input channel (in_valid_i / in_ready_o) carries one command per transfer:
//   load   - stores position and velocity, one result
//   step   - one step with factor time_scale*19968, one result
//   predict- step_count steps (1..64) on a scratch copy, one result each,
//            last_o on the final one; the live state is left unchanged.
// One step runs fourteen passes through the shared multiplier (start, four
// partial products, done), a square root and two divisions in the shared
// shift-subtract unit, and the result state. A division that saturates skips
// the shift-subtract steps. in_ready_o is high only while the sequencer is
// idle; a command code of 3 is taken and dropped. Results leave through an
// output register (out_valid_o / out_ready_i); a stalled receiver holds the
// sequencer at the end of the next result, but the following command is taken
// while the last result still waits. Configuration writes (cfg_we_i) take
// effect at once and belong between commands. Reset restores the register
// defaults and clears the body state and the valid flag of the output
// register.
`timescale 1ns / 1ps
`include "central_gravity_orbit_step_macros.svh"
module central_gravity_orbit_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] load_pos_x_i,
  input  logic [63:0] load_pos_y_i,
  input  logic [63:0] load_vel_x_i,
  input  logic [63:0] load_vel_y_i,
  input  logic [31:0] time_scale_i,
  input  logic [6:0]  step_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] world_x_o,
  output logic [63:0] world_y_o,
  output logic        last_o,
  output logic        saturated_o
);
  import cgos_pkg::*;

  localparam logic [63:0] WS_RESET = 64'd4294967296;
  localparam logic [63:0] GC_RESET = 64'd4294967296;
  localparam logic [63:0] MD_RESET = 64'd42949672960000;

  function automatic logic [64:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (!(a[63] ^ b[63]) && (a[63] ^ r[63])) begin
      return {1'b1, a[63] ? SIGN_BIT : POS_MAX};
    end
    return {1'b0, r};
  endfunction

  // Negation with saturation of the most negative value
  function automatic logic [64:0] neg_sat(input logic [63:0] x);
    if (x == SIGN_BIT) begin
      return {1'b1, POS_MAX};
    end
    return {1'b0, ~x + 64'd1};
  endfunction

  state_e      state_q, state_d;
  cmd_e        cmd_q;
  logic [63:0] ws_q, gc_q, md_q;
  logic [63:0] pos_q [2];
  logic [63:0] vel_q [2];
  logic [63:0] wp_q [2];
  logic [63:0] wv_q [2];
  logic [63:0] d_q [2];
  logic [63:0] wout_q [2];
  logic [63:0] d2_q, inv_q, accel_q, tmp_q, k_q;
  logic [CNT_W-1:0] cnt_q;
  logic        i_q, issued_q, sat_acc_q;
  logic        out_valid_q, last_q, sat_out_q;
  logic [63:0] world_x_q, world_y_q;

  mul_req_t    mul_req;
  div_req_t    div_req;
  unit_stat_t  mul_stat, div_stat;
  logic [63:0] mul_a, mul_b, mul_res;
  logic [63:0] div_hi, div_lo, div_den, div_res;
  logic        in_fire, op_done, op_sat, out_load, last_now, sat_evt;
  logic [63:0] d2_clamp;
  logic [46:0] k_scaled;
  logic [CNT_W-1:0] cnt_in;
  logic [64:0] d2_sum, sum_r, neg_r;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign op_done    = mul_stat.done || div_stat.done;
  assign op_sat     = (mul_stat.done && mul_stat.sat) || (div_stat.done && div_stat.sat);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign last_now   = (cmd_q != CMD_PREDICT) || (cnt_q == CNT_W'(1));
  assign d2_clamp   = (d2_q < md_q) ? md_q : d2_q;
  assign k_scaled   = 47'(time_scale_i) * 47'(STEP_FACTOR);
  assign d2_sum     = {1'b0, d2_q} + {1'b0, mul_res};
  assign neg_r      = neg_sat(mul_res);

  // Saturation raised by the operation finishing this cycle
  assign sat_evt = op_sat ||
                   (state_q == ST_DX && neg_r[64]) ||
                   (state_q == ST_SQ && i_q && d2_sum[64]) ||
                   ((state_q == ST_A3 || state_q == ST_PV) && sum_r[64]);

  // Clamp the requested prediction count to 1..MAX_PREDICT
  always_comb begin
    if (step_count_i == '0) begin
      cnt_in = CNT_W'(1);
    end else if (step_count_i > CNT_W'(MAX_PREDICT)) begin
      cnt_in = CNT_W'(MAX_PREDICT);
    end else begin
      cnt_in = step_count_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (command_i == CMD_LOAD) begin
            state_d = ST_PW;
          end else if (command_i == CMD_STEP || command_i == CMD_PREDICT) begin
            state_d = ST_DX;
          end
        end
      end
      ST_DX:   if (op_done && i_q) state_d = ST_SQ;
      ST_SQ:   if (op_done && i_q) state_d = ST_ROOT;
      ST_ROOT: if (op_done) state_d = ST_INV;
      ST_INV:  if (op_done) state_d = ST_ACC;
      ST_ACC:  if (op_done) state_d = ST_A1;
      ST_A1:   if (op_done) state_d = ST_A2;
      ST_A2:   if (op_done) state_d = ST_A3;
      ST_A3:   if (op_done) state_d = i_q ? ST_PV : ST_A1;
      ST_PV:   if (op_done) state_d = ST_PW;
      ST_PW: begin
        if (op_done) begin
          if (i_q) begin
            state_d = ST_OUT;
          end else if (cmd_q == CMD_LOAD) begin
            state_d = ST_PW;
          end else begin
            state_d = ST_PV;
          end
        end
      end
      ST_OUT:  if (out_load) state_d = last_now ? ST_IDLE : ST_DX;
      default: state_d = ST_IDLE;
    endcase
  end

  // Unit requests and operand selection
  always_comb begin
    mul_req = '0;
    div_req = '0;
    mul_a   = wp_q[i_q];
    mul_b   = ws_q;
    div_hi  = 64'd0;
    div_lo  = d2_q;
    div_den = 64'd0;
    unique case (state_q)
      ST_DX, ST_PW: begin
        mul_req = '{start: !issued_q, is_signed: 1'b1};
      end
      ST_SQ: begin
        mul_req = '{start: !issued_q, is_signed: 1'b0};
        mul_a   = magnitude(d_q[i_q]);
        mul_b   = magnitude(d_q[i_q]);
      end
      ST_ROOT: begin
        div_req = '{start: !issued_q, sqrt_mode: 1'b1};
      end
      ST_INV: begin
        div_req = '{start: !issued_q, sqrt_mode: 1'b0};
        div_hi  = 64'd1;
        div_lo  = 64'd0;
        div_den = inv_q;
      end
      ST_ACC: begin
        div_req = '{start: !issued_q, sqrt_mode: 1'b0};
        div_hi  = {32'd0, gc_q[63:32]};
        div_lo  = {gc_q[31:0], 32'd0};
        div_den = d2_clamp;
      end
      ST_A1: begin
        mul_req = '{start: !issued_q, is_signed: 1'b1};
        mul_a   = d_q[i_q];
        mul_b   = inv_q;
      end
      ST_A2: begin
        mul_req = '{start: !issued_q, is_signed: 1'b1};
        mul_a   = tmp_q;
        mul_b   = accel_q;
      end
      ST_A3: begin
        mul_req = '{start: !issued_q, is_signed: 1'b1};
        mul_a   = tmp_q;
        mul_b   = k_q;
      end
      ST_PV: begin
        mul_req = '{start: !issued_q, is_signed: 1'b1};
        mul_a   = wv_q[i_q];
        mul_b   = k_q;
      end
      default: begin
      end
    endcase
  end

  // Saturating accumulate into velocity or position
  always_comb begin
    if (state_q == ST_A3) begin
      sum_r = sadd(wv_q[i_q], mul_res);
    end else begin
      sum_r = sadd(wp_q[i_q], mul_res);
    end
  end

  cgos_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .stat_o (mul_stat),
    .res_o  (mul_res)
  );

  cgos_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .hi_i   (div_hi),
    .lo_i   (div_lo),
    .den_i  (div_den),
    .stat_o (div_stat),
    .res_o  (div_res)
  );

  // Control state, configuration and body state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= CMD_LOAD;
      issued_q    <= 1'b0;
      i_q         <= 1'b0;
      cnt_q       <= '0;
      sat_acc_q   <= 1'b0;
      out_valid_q <= 1'b0;
      ws_q        <= WS_RESET;
      gc_q        <= GC_RESET;
      md_q        <= MD_RESET;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      vel_q[0]    <= '0;
      vel_q[1]    <= '0;
    end else begin
      state_q <= state_d;

      // configuration writes; index 3 is ignored
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_WORLD_SCALE: ws_q <= cfg_data_i;
          CFG_GRAVITY:     gc_q <= cfg_data_i;
          CFG_MIN_DIST2:   md_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // one request per operation
      if (op_done) begin
        issued_q <= 1'b0;
      end else if (mul_req.start || div_req.start) begin
        issued_q <= 1'b1;
      end

      if (op_done && (state_q == ST_DX || state_q == ST_SQ || state_q == ST_A3 ||
                      state_q == ST_PW)) begin
        i_q <= !i_q;
      end

      if (op_done) begin
        sat_acc_q <= sat_acc_q | sat_evt;
      end

      if (in_fire) begin
        i_q       <= 1'b0;
        sat_acc_q <= 1'b0;
        cnt_q     <= cnt_in;
        if (command_i == CMD_LOAD) begin
          cmd_q    <= CMD_LOAD;
          pos_q[0] <= load_pos_x_i;
          pos_q[1] <= load_pos_y_i;
          vel_q[0] <= load_vel_x_i;
          vel_q[1] <= load_vel_y_i;
        end else if (command_i == CMD_STEP) begin
          cmd_q <= CMD_STEP;
        end else if (command_i == CMD_PREDICT) begin
          cmd_q <= CMD_PREDICT;
        end
      end

      // result register
      if (out_load) begin
        out_valid_q <= 1'b1;
        sat_acc_q   <= 1'b0;
        i_q         <= 1'b0;
        cnt_q       <= cnt_q - CNT_W'(1);
        if (cmd_q == CMD_STEP) begin
          pos_q <= wp_q;
          vel_q <= wv_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working copy and intermediate values
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (command_i == CMD_LOAD) begin
        wp_q[0] <= load_pos_x_i;
        wp_q[1] <= load_pos_y_i;
        wv_q[0] <= load_vel_x_i;
        wv_q[1] <= load_vel_y_i;
      end else begin
        wp_q <= pos_q;
        wv_q <= vel_q;
      end
      if (command_i == CMD_STEP) begin
        k_q <= {9'd0, k_scaled, 8'd0};
      end else begin
        k_q <= {17'd0, STEP_FACTOR, 32'd0};
      end
    end
    if (op_done) begin
      unique case (state_q)
        ST_DX:   d_q[i_q] <= neg_r[63:0];
        ST_SQ:   d2_q <= i_q ? (d2_sum[64] ? '1 : d2_sum[63:0]) : mul_res;
        ST_ROOT: inv_q <= div_res;
        ST_INV:  inv_q <= div_res;
        ST_ACC:  accel_q <= div_res;
        ST_A1:   tmp_q <= mul_res;
        ST_A2:   tmp_q <= mul_res;
        ST_A3:   wv_q[i_q] <= sum_r[63:0];
        ST_PV:   wp_q[i_q] <= sum_r[63:0];
        ST_PW:   wout_q[i_q] <= mul_res;
        default: begin
        end
      endcase
    end
    if (out_load) begin
      world_x_q <= wout_q[0];
      world_y_q <= wout_q[1];
      last_q    <= last_now;
      sat_out_q <= sat_acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign world_x_o   = world_x_q;
  assign world_y_o   = world_y_q;
  assign last_o      = last_q;
  assign saturated_o = sat_out_q;

  `CGOS_ASSERT_NOW(a_one_unit, clk_i, rst_ni, 1'b1, !(mul_req.start && div_req.start), "both units started")
  `CGOS_ASSERT_NOW(a_cnt_live, clk_i, rst_ni, state_q != ST_IDLE && cmd_q == CMD_PREDICT, cnt_q != '0, "predict count exhausted")
  `CGOS_ASSERT_NEXT(a_out_set, clk_i, rst_ni, out_load, out_valid_o, "result not presented")

endmodule
